/* src/euler_rotate_double_integrate_top_defines.svh */
// Assertion macros for the dead reckoning top level.
// No dependencies; included by the top level only.
`ifndef EULER_ROTATE_DOUBLE_INTEGRATE_TOP_DEFINES_SVH
`define EULER_ROTATE_DOUBLE_INTEGRATE_TOP_DEFINES_SVH
// implication checked on every edge outside reset
`define ERDI_ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define ERDI_ASSERT_NXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

/* src/erdi_pkg.sv */
// Shared types, constants and the arctangent table for the dead reckoning block.
// No dependencies.
`timescale 1ns / 1ps
package erdi_pkg;
  localparam int SampleWidth = 16;
  localparam int AccWidth = 32;
  localparam int CordicIters = 16;

  typedef enum logic [2:0] {
    REG_GAIN = 3'd0, REG_OFF_X = 3'd1, REG_OFF_Y = 3'd2, REG_OFF_Z = 3'd3, REG_DT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
  } out_beat_t;

  function automatic logic signed [16:0] atan_entry(input logic [3:0] i);
    case (i)
      4'd0: atan_entry = 17'sd8192;  4'd1: atan_entry = 17'sd4836;
      4'd2: atan_entry = 17'sd2555;  4'd3: atan_entry = 17'sd1297;
      4'd4: atan_entry = 17'sd651;   4'd5: atan_entry = 17'sd326;
      4'd6: atan_entry = 17'sd163;   4'd7: atan_entry = 17'sd81;
      4'd8: atan_entry = 17'sd41;    4'd9: atan_entry = 17'sd20;
      4'd10: atan_entry = 17'sd10;   4'd11: atan_entry = 17'sd5;
      4'd12: atan_entry = 17'sd3;    4'd13: atan_entry = 17'sd1;
      4'd14: atan_entry = 17'sd1;    default: atan_entry = 17'sd0;
    endcase
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [19:0] v);
    if (v > 20'sd32767) clamp16 = 16'sh7fff;
    else if (v < -20'sd32768) clamp16 = 16'sh8000;
    else clamp16 = v[15:0];
  endfunction
endpackage

/* src/erdi_cordic_lane.sv */
// One sine/cosine lane: iterative CORDIC, one micro-rotation per cycle.
// Depends on erdi_pkg.
`timescale 1ns / 1ps
module erdi_cordic_lane import erdi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               busy,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q
);
  logic signed [19:0] x, y;
  logic signed [17:0] z;
  logic [3:0] iter;
  logic flip;
  logic [15:0] neg, fold;
  logic signed [19:0] x_out, y_out;

  assign neg = 16'd0 - angle;
  assign fold = neg + 16'h8000;
  assign x_out = flip ? -x : x;
  assign y_out = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
      x <= 20'sd19898;
      y <= '0;
      if ($signed(neg) > 16'sd16384 || $signed(neg) < -16'sd16384) begin
        flip <= 1'b1;
        z <= 18'($signed(fold));
      end else begin
        flip <= 1'b0;
        z <= 18'($signed(neg));
      end
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - (y >>> iter);
        y <= y + (x >>> iter);
        z <= z - 18'(atan_entry(iter));
      end else begin
        x <= x + (y >>> iter);
        y <= y - (x >>> iter);
        z <= z + 18'(atan_entry(iter));
      end
      iter <= iter + 4'd1;
      if (iter == 4'(CordicIters - 1)) busy <= 1'b0;
    end
  end

  assign cos_q = clamp16(x_out);
  assign sin_q = clamp16(y_out);
endmodule

/* src/erdi_merge.sv */
// Merging stage: builds the rotation matrix from the three lanes, rotates,
// removes offset and integrates, one multiply per cycle. Depends on erdi_pkg.
`timescale 1ns / 1ps
module erdi_merge import erdi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] sa, ca, sb, cb, sc, cc,
  input  logic signed [15:0] u0, u1, u2,
  input  logic signed [15:0] off_x, off_y, off_z,
  input  logic [15:0]        dt,
  output logic               done,
  output out_beat_t          res
);
  typedef enum logic [1:0] {M_IDLE, M_RUN} mstate_t;
  mstate_t st;
  logic [5:0] step;
  logic signed [31:0] m [9];
  logic signed [31:0] t1, t2;
  logic signed [47:0] accf;
  logic signed [31:0] f [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] disp [3];
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] dt_s;
  logic [1:0] ax;

  assign dt_s = {16'd0, dt};
  assign prod = 64'(ma) * 64'(mb);
  assign t2 = '0;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7fffffff) sat32 = 32'sh7fffffff;
    else if (v < -64'sh80000000) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // operand schedule: matrix 0..13, rotation 14..22, offsets 23, vel 24..26, disp 27..29
  always_comb begin
    ma = '0; mb = '0; ax = 2'd0;
    case (step)
      6'd0: begin ma = 32'(ca); mb = 32'(cb); end
      6'd1: begin ma = 32'(sa); mb = 32'(cb); end
      6'd2: begin ma = 32'(cb); mb = 32'(sc); end
      6'd3: begin ma = 32'(cb); mb = 32'(cc); end
      6'd4: begin ma = 32'(ca); mb = 32'(sb); end
      6'd5: begin ma = t1; mb = 32'(sc); end
      6'd6: begin ma = t1; mb = 32'(cc); end
      6'd7: begin ma = 32'(sa); mb = 32'(cc); end
      6'd8: begin ma = 32'(sa); mb = 32'(sc); end
      6'd9: begin ma = 32'(sa); mb = 32'(sb); end
      6'd10: begin ma = t1; mb = 32'(sc); end
      6'd11: begin ma = t1; mb = 32'(cc); end
      6'd12: begin ma = 32'(ca); mb = 32'(cc); end
      6'd13: begin ma = 32'(ca); mb = 32'(sc); end
      6'd14, 6'd17, 6'd20: begin ma = 32'(u0); mb = m[4'(step - 6'd14)]; end
      6'd15, 6'd18, 6'd21: begin ma = 32'(u1); mb = m[4'(step - 6'd14)]; end
      6'd16, 6'd19, 6'd22: begin ma = 32'(u2); mb = m[4'(step - 6'd14)]; end
      6'd24, 6'd25, 6'd26: begin ax = 2'(step - 6'd24); ma = f[ax]; mb = dt_s; end
      6'd27, 6'd28, 6'd29: begin ax = 2'(step - 6'd27); ma = vel[ax]; mb = dt_s; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= M_IDLE;
      done <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vel[i] <= '0;
        disp[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (st)
        M_IDLE: if (start) begin
          st <= M_RUN;
          step <= '0;
        end
        M_RUN: begin
          step <= step + 6'd1;
          case (step)
            6'd0: m[0] <= 32'(prod >>> 15);
            6'd1: m[3] <= 32'(prod >>> 15);
            6'd2: m[7] <= 32'(prod >>> 15);
            6'd3: begin m[8] <= 32'(prod >>> 15); m[6] <= -32'(sb); end
            6'd4, 6'd9: t1 <= 32'(prod >>> 15);
            6'd5: m[1] <= 32'(prod >>> 15);
            6'd6: m[2] <= 32'(prod >>> 15);
            6'd7: m[1] <= m[1] - 32'(prod >>> 15);
            6'd8: m[2] <= m[2] + 32'(prod >>> 15);
            6'd10: m[4] <= 32'(prod >>> 15);
            6'd11: m[5] <= 32'(prod >>> 15);
            6'd12: m[4] <= m[4] + 32'(prod >>> 15);
            6'd13: m[5] <= m[5] - 32'(prod >>> 15);
            6'd14, 6'd17, 6'd20: accf <= 48'(prod);
            6'd15, 6'd18, 6'd21: accf <= accf + 48'(prod);
            6'd16: f[0] <= 32'((accf + 48'(prod)) >>> 15);
            6'd19: f[1] <= 32'((accf + 48'(prod)) >>> 15);
            6'd22: f[2] <= 32'((accf + 48'(prod)) >>> 15);
            6'd23: begin
              f[0] <= f[0] - 32'(off_x);
              f[1] <= f[1] - 32'(off_y);
              f[2] <= f[2] - 32'(off_z);
            end
            6'd24, 6'd25, 6'd26: vel[ax] <= sat32(64'(vel[ax]) + (prod >>> 12));
            6'd27, 6'd28, 6'd29: begin
              // floor(v*dt/65536) equals hi*dt + ((lo*dt)>>16)
              disp[ax] <= sat32(64'(disp[ax]) + (prod >>> 16));
              if (step == 6'd29) begin
                st <= M_IDLE;
                done <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: st <= M_IDLE;
      endcase
    end
  end

  assign res = '{vel_x: vel[0], vel_y: vel[1], vel_z: vel[2],
                 disp_x: disp[0], disp_y: disp[1], disp_z: disp[2]};
endmodule

/* src/euler_rotate_double_integrate_top.sv */
// Top level of the strapdown dead reckoning block.
// Depends on erdi_pkg, erdi_cordic_lane, erdi_merge and the defines header.
`timescale 1ns / 1ps
`include "euler_rotate_double_integrate_top_defines.svh"
// One sample at a time: a new sample is accepted only once the previous result
// has left the merging stage. Three CORDIC lanes run the yaw, pitch and roll
// sines and cosines together; the merging stage starts in the cycle after they
// finish, and its single shared multiplier takes 30 steps for matrix, rotation
// and both integrations, after which the result moves to the output register.
// The output register holds a result while the next sample is accepted and
// its trig is running; a result that cannot leave stalls the input.
module euler_rotate_double_integrate_top import erdi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] accel_gain, time_step;
  logic signed [15:0] off_x, off_y, off_z;
  logic signed [15:0] u [3];
  logic signed [15:0] sa, ca, sb, cb, sc, cc;
  logic active;
  logic busy_a, busy_b, busy_c, busy_d;
  logic mdone, hold_merge, lanes_busy;
  out_beat_t mres;
  logic in_acc;
  logic take_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_gain <= 16'd256; time_step <= 16'd655;
      off_x <= '0; off_y <= '0; off_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN: accel_gain <= cfg_data;
        REG_OFF_X: off_x <= cfg_data;
        REG_OFF_Y: off_y <= cfg_data;
        REG_OFF_Z: off_z <= cfg_data;
        REG_DT: time_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // busy from accept until merge has handed its result to the output register
  assign in_stall = active || hold_merge;
  assign in_acc = in_valid && !in_stall;
  assign lanes_busy = busy_a;
  assign take_res = (hold_merge || mdone) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      busy_d <= 1'b0;
      hold_merge <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy_d <= lanes_busy;
      if (in_acc) active <= 1'b1;
      else if (mdone) active <= 1'b0;
      hold_merge <= (hold_merge || mdone) && !take_res;
      out_valid <= take_res || (out_valid && out_stall);
      if (take_res) out_data <= mres;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      u[0] <= clamp16(20'((32'(in_data.accel_x) * $signed({1'b0, accel_gain})) >>> 8 > 32'sd40000 ?
              32'sd40000 : (32'(in_data.accel_x) * $signed({1'b0, accel_gain})) >>> 8 < -32'sd40000 ?
              -32'sd40000 : (32'(in_data.accel_x) * $signed({1'b0, accel_gain})) >>> 8));
      u[1] <= clamp16(20'((32'(in_data.accel_y) * $signed({1'b0, accel_gain})) >>> 8 > 32'sd40000 ?
              32'sd40000 : (32'(in_data.accel_y) * $signed({1'b0, accel_gain})) >>> 8 < -32'sd40000 ?
              -32'sd40000 : (32'(in_data.accel_y) * $signed({1'b0, accel_gain})) >>> 8));
      u[2] <= clamp16(20'((32'(in_data.accel_z) * $signed({1'b0, accel_gain})) >>> 8 > 32'sd40000 ?
              32'sd40000 : (32'(in_data.accel_z) * $signed({1'b0, accel_gain})) >>> 8 < -32'sd40000 ?
              -32'sd40000 : (32'(in_data.accel_z) * $signed({1'b0, accel_gain})) >>> 8));
    end
  end

  erdi_cordic_lane u_yaw (.clk, .rst, .start(in_acc), .angle(in_data.yaw_angle),
    .busy(busy_a), .sin_q(sa), .cos_q(ca));
  erdi_cordic_lane u_pitch (.clk, .rst, .start(in_acc), .angle(in_data.pitch_angle),
    .busy(busy_b), .sin_q(sb), .cos_q(cb));
  erdi_cordic_lane u_roll (.clk, .rst, .start(in_acc), .angle(in_data.roll_angle),
    .busy(busy_c), .sin_q(sc), .cos_q(cc));

  erdi_merge u_merge (.clk, .rst, .start(busy_d && !lanes_busy),
    .sa, .ca, .sb, .cb, .sc, .cc, .u0(u[0]), .u1(u[1]), .u2(u[2]),
    .off_x, .off_y, .off_z, .dt(time_step), .done(mdone), .res(mres));

  `ERDI_ASSERT_IMP(a_lanes_agree, 1'b1, busy_a == busy_b && busy_b == busy_c,
    "CORDIC lanes out of step")
  `ERDI_ASSERT_IMP(a_no_accept_busy, active, in_stall, "sample accepted while busy")
  `ERDI_ASSERT_NXT(a_done_held, mdone, hold_merge || out_valid, "merge result dropped")
endmodule

/* tb/sv/erdi_checker.sv */
// Checker for the dead reckoning block: watches the config port and both channels,
// predicts each result beat and compares it field by field. Depends on erdi_pkg.
`timescale 1ns / 1ps
module erdi_checker import erdi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_beat_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_beat_t  out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int         errors,
  output int         awaited,
  output int         samples_taken,
  output int         results_seen
);

  longint gain, dt;
  longint offs [3];
  longint vel [3];
  longint disp [3];
  out_beat_t nav_expected [$];

  function automatic longint clamp_to(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint sext16(input longint v);
    logic signed [15:0] t;
    t = v[15:0];
    return longint'(t);
  endfunction

  // CORDIC sine/cosine, Q1.15, folded into the half turn around zero
  task automatic trig(input logic [15:0] ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    x = 19898;
    y = 0;
    z = sext16(longint'(ang));
    flip = 0;
    if (z > 16384 || z < -16384) begin
      z = sext16(z + 32768);
      flip = 1;
    end
    for (int i = 0; i < CordicIters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_entry(4'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_entry(4'(i)));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clamp_to(x, 16);
    s = clamp_to(y, 16);
  endtask

  function automatic longint m15(input longint p, input longint q);
    return (p * q) >>> 15;
  endfunction

  task automatic advance_nav(input in_beat_t b, output out_beat_t r);
    longint u [3];
    longint m [3][3];
    longint f, v, hi, lo;
    longint sa, ca, sb, cb, sc, cc;
    u[0] = clamp_to((longint'(b.accel_x) * gain) >>> 8, SampleWidth);
    u[1] = clamp_to((longint'(b.accel_y) * gain) >>> 8, SampleWidth);
    u[2] = clamp_to((longint'(b.accel_z) * gain) >>> 8, SampleWidth);
    // negate the angles; minus a half turn wraps to itself
    trig(16'(16'd0 - b.yaw_angle), sa, ca);
    trig(16'(16'd0 - b.pitch_angle), sb, cb);
    trig(16'(16'd0 - b.roll_angle), sc, cc);
    m[0][0] = m15(ca, cb);
    m[0][1] = m15(m15(ca, sb), sc) - m15(sa, cc);
    m[0][2] = m15(m15(ca, sb), cc) + m15(sa, sc);
    m[1][0] = m15(sa, cb);
    m[1][1] = m15(m15(sa, sb), sc) + m15(ca, cc);
    m[1][2] = m15(m15(sa, sb), cc) - m15(ca, sc);
    m[2][0] = -sb;
    m[2][1] = m15(cb, sc);
    m[2][2] = m15(cb, cc);
    for (int i = 0; i < 3; i++) begin
      f = ((u[0] * m[i][0] + u[1] * m[i][1] + u[2] * m[i][2]) >>> 15) - offs[i];
      v = clamp_to(vel[i] + ((f * dt) >>> 12), AccWidth);
      vel[i] = v;
      hi = v >>> 16;
      lo = v - hi * 65536;
      disp[i] = clamp_to(disp[i] + hi * dt + ((lo * dt) >>> 16), AccWidth);
    end
    r.vel_x = 32'(clamp_to(vel[0], 32));
    r.vel_y = 32'(clamp_to(vel[1], 32));
    r.vel_z = 32'(clamp_to(vel[2], 32));
    r.disp_x = 32'(clamp_to(disp[0], 32));
    r.disp_y = 32'(clamp_to(disp[1], 32));
    r.disp_z = 32'(clamp_to(disp[2], 32));
  endtask

  task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_beat_t r;
    out_beat_t want;
    if (rst) begin
      gain = 256; dt = 655;
      for (int i = 0; i < 3; i++) begin
        offs[i] = 0; vel[i] = 0; disp[i] = 0;
      end
      nav_expected.delete();
      errors <= 0;
      awaited <= 0;
      samples_taken <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_GAIN:  gain = longint'(cfg_data);
          REG_OFF_X: offs[0] = sext16(longint'(cfg_data));
          REG_OFF_Y: offs[1] = sext16(longint'(cfg_data));
          REG_OFF_Z: offs[2] = sext16(longint'(cfg_data));
          REG_DT:    dt = longint'(cfg_data);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (nav_expected.size() == 0) begin
          $error("result beat with no sample outstanding");
          errors++;
        end else begin
          want = nav_expected.pop_front();
          cmp("vel_x", want.vel_x, out_data.vel_x);
          cmp("vel_y", want.vel_y, out_data.vel_y);
          cmp("vel_z", want.vel_z, out_data.vel_z);
          cmp("disp_x", want.disp_x, out_data.disp_x);
          cmp("disp_y", want.disp_y, out_data.disp_y);
          cmp("disp_z", want.disp_z, out_data.disp_z);
        end
      end
      if (in_valid && !in_stall) begin
        advance_nav(in_data, r);
        nav_expected.push_back(r);
        samples_taken <= samples_taken + 1;
      end
      awaited <= nav_expected.size();
    end
  end

  final begin
    if (nav_expected.size() != 0) $display("%0d result beats never arrived",
                                           nav_expected.size());
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the dead reckoning testbench: clock, reset, config phases and sample stimulus.
// Depends on erdi_pkg, erdi_checker and euler_rotate_double_integrate_top.
`timescale 1ns / 1ps
module testbench;
  import erdi_pkg::*;

  localparam int CycleLimit = 900000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_beat_t out_data;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int errors, awaited, samples_taken, results_seen;
  int cycles = 0;
  bit quiet = 0;
  bit sender_idle = 1;
  int hold_asked = 0;
  int hold_done = 0;
  int stall_left = 0;
  int run_left = 0;
  int hold_left = 0;

  euler_rotate_double_integrate_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  erdi_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .awaited(awaited),
    .samples_taken(samples_taken), .results_seen(results_seen)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold on request, none at the end
  always @(negedge clk) begin
    if (rst) begin
      out_stall = 0;
    end else if (hold_asked != hold_done && hold_left == 0) begin
      hold_left = 600;
      hold_done = hold_asked;
      out_stall = 1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall = (hold_left != 0);
    end else if (quiet) begin
      out_stall = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall = 0;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_stall = 1;
    end else begin
      run_left = $urandom_range(1, 40);
      out_stall = 0;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_config(input logic [15:0] g, input logic [15:0] ox,
                            input logic [15:0] oy, input logic [15:0] oz,
                            input logic [15:0] step);
    write_reg(REG_GAIN, g);
    write_reg(REG_OFF_X, ox);
    write_reg(REG_OFF_Y, oy);
    write_reg(REG_OFF_Z, oz);
    write_reg(REG_DT, step);
  endtask

  // drop valid and wait until every result is back, then let the block settle
  task automatic drain;
    in_valid = 0;
    sender_idle = 1;
    while (awaited != 0 || samples_taken != results_seen) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // offer one beat and hold it until taken
  task automatic feed(input in_beat_t b);
    int taken;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    taken = samples_taken;
    in_data = b;
    in_valid = 1;
    sender_idle = 0;
    @(negedge clk);
    while (samples_taken == taken) @(negedge clk);
  endtask

  function automatic in_beat_t mk(input int ax, input int ay, input int az,
                                  input int r, input int p, input int y);
    in_beat_t b;
    b.accel_x = 16'(ax); b.accel_y = 16'(ay); b.accel_z = 16'(az);
    b.roll_angle = 16'(r); b.pitch_angle = 16'(p); b.yaw_angle = 16'(y);
    return b;
  endfunction

  function automatic in_beat_t rand_beat(input bit tame);
    in_beat_t b;
    b = in_beat_t'({$urandom, $urandom, $urandom});
    if (tame) begin
      // gentle motion: near-level attitude, about 1 g on z
      b.accel_x = 16'($signed($urandom_range(0, 4000)) - 2000);
      b.accel_y = 16'($signed($urandom_range(0, 4000)) - 2000);
      b.accel_z = 16'($signed($urandom_range(2096, 6096)));
      b.roll_angle = 16'($signed($urandom_range(0, 8000)) - 4000);
      b.pitch_angle = 16'($signed($urandom_range(0, 8000)) - 4000);
    end
    return b;
  endfunction

  initial begin
    repeat (7) @(negedge clk);
    rst = 0;

    // defaults written back explicitly, then edge cases of fields and angles
    set_config(16'd256, 16'd0, 16'd0, 16'd0, 16'd655);
    feed(mk(0, 0, 0, 0, 0, 0));
    feed(mk(4096, 0, 0, 0, 0, 0));
    feed(mk(0, 4096, 0, 16384, 0, 0));
    feed(mk(0, 0, 4096, 0, 16384, 0));
    feed(mk(4096, 4096, 4096, 0, 0, 16384));
    feed(mk(32767, 32767, 32767, 0, 0, 0));
    feed(mk(-32768, -32768, -32768, 0, 0, 0));
    feed(mk(4096, 0, 0, -32768, -32768, -32768));
    feed(mk(4096, -4096, 4096, 32767, 32767, 32767));
    feed(mk(-4096, 4096, 0, -16384, -16384, -16384));
    feed(mk(1000, 2000, 3000, 16385, -16385, 16383));
    feed(mk(-1, -1, -1, 1, -1, 1));
    feed(mk(32767, -32768, 32767, 8192, -8192, 24576));
    feed(mk(-32768, 32767, -32768, -24576, 24576, -8192));
    drain();

    // gain of zero: only the offsets get integrated
    set_config(16'd0, 16'h7fff, 16'h8000, 16'd1234, 16'd65535);
    feed(mk(32767, 32767, 32767, 0, 0, 0));
    feed(mk(-32768, 12, 4096, 100, 200, 300));
    feed(mk(5, -5, 7, -32768, 16384, -16384));
    drain();

    // full gain and step: accelerations clamp, displacement heads for saturation
    set_config(16'hffff, 16'h8000, 16'h7fff, 16'h8000, 16'hffff);
    for (int i = 0; i < 120; i++) feed(mk(32767, -32768, 32767, 0, 0, 0));
    drain();

    // zero step: nothing may move
    set_config(16'd300, 16'd77, 16'hff00, 16'd0, 16'd0);
    for (int i = 0; i < 4; i++) feed(rand_beat(0));
    drain();

    // long receiver hold while beats keep coming, so the input backs up
    set_config(16'd256, 16'd0, 16'd0, 16'd4096, 16'd655);
    hold_asked++;
    for (int i = 0; i < 8; i++) feed(rand_beat(1));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom_range(0, 2000)));
      if (ph == 3) quiet = 1;
      for (int i = 0; i < 170; i++) begin
        feed(rand_beat($urandom_range(0, 3) != 0));
        if (!quiet && $urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    repeat (100) @(negedge clk);
    $display("ran %0d samples, %0d result beats, across gain, offset and step settings",
             samples_taken, results_seen);
    $display("including zero and full-scale registers, wrapped angles and a stalled output");
    if (errors == 0 && awaited == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
